### rtl/core/are_pkg.sv
// Shared types and constants for the ARP resolution engine.
`timescale 1ns / 1ps
`default_nettype none
package are_pkg;

   localparam int unsigned TableEntriesDefault   = 16;
   localparam int unsigned PendingEntriesDefault = 8;
   localparam int unsigned HandleBitsDefault     = 8;

   localparam logic [15:0] HW_TYPE_ETH   = 16'h0001;
   localparam logic [15:0] PROTO_IPV4    = 16'h0800;
   localparam logic [7:0]  HW_LEN_MAC    = 8'd6;
   localparam logic [7:0]  PROTO_LEN_IP  = 8'd4;
   localparam logic [15:0] OPCODE_REQ    = 16'd1;
   localparam logic [15:0] OPCODE_REPLY  = 16'd2;

   localparam logic [0:0] OP_RX  = 1'b0;
   localparam logic [0:0] OP_OUT = 1'b1;

   localparam logic [1:0] ACT_REQUEST = 2'd0;
   localparam logic [1:0] ACT_REPLY   = 2'd1;
   localparam logic [1:0] ACT_FORWARD = 2'd2;

   localparam logic [0:0] CSR_OWN_IP  = 1'b0;
   localparam logic [0:0] CSR_OWN_MAC = 1'b1;

   typedef struct packed {
      logic [0:0]  op;
      logic        length_ok;
      logic [15:0] hw_type;
      logic [15:0] proto_type;
      logic [7:0]  hw_len;
      logic [7:0]  proto_len;
      logic [15:0] opcode;
      logic [31:0] src_ip;
      logic [47:0] src_mac;
      logic [31:0] dst_ip;
      logic [7:0]  packet_handle;
   } req_type;

   typedef struct packed {
      logic [1:0]  out_action;
      logic [47:0] out_mac;
      logic [31:0] out_ip;
      logic [7:0]  out_handle;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic load;    // capture request beat
      logic commit;  // update tables and drive the result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic emit;    // captured beat yields a result
   } sts_type;

endpackage
`default_nettype wire

### rtl/core/are_ctrl.sv
// Controller: sequences capture and commit of one beat.
`timescale 1ns / 1ps
`default_nettype none
module are_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   output are_pkg::cmd_type      cmd,
   input  are_pkg::sts_type      sts
);
   import are_pkg::*;

   typedef enum logic [0:0] {S_IDLE, S_COMMIT} state_type;
   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE:   if (start) state_ff <= S_COMMIT;
            S_COMMIT: state_ff <= S_IDLE;
            default:  state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy       = (state_ff == S_COMMIT);
   assign cmd.load   = start && !busy;
   assign cmd.commit = (state_ff == S_COMMIT);

`ifndef SYNTHESIS
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> !cmd.commit) else $error("commit twice in a row");
   a_load_commit: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.commit) else $error("load not followed by commit");
   a_emit_known: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !$isunknown(sts.emit)) else $error("result flag unknown at commit");
`endif
endmodule
`default_nettype wire

### rtl/core/are_dp.sv
// Datapath: resolution table, pending queue and result register.
`timescale 1ns / 1ps
`default_nettype none
module are_dp #(
   parameter int unsigned TABLE_ENTRIES   = are_pkg::TableEntriesDefault,
   parameter int unsigned PENDING_ENTRIES = are_pkg::PendingEntriesDefault,
   parameter int unsigned HANDLE_BITS     = are_pkg::HandleBitsDefault
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  are_pkg::req_type      req_data,
   input  are_pkg::cmd_type      cmd,
   output are_pkg::sts_type      sts,
   input  wire logic [31:0]      own_ip,
   output logic                  rsp_valid,
   output are_pkg::rsp_type      rsp_data
);
   import are_pkg::*;

   localparam int TW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int PW = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
   // stored handle bits, never wider than the handle field
   localparam int HB = (HANDLE_BITS < 8) ? HANDLE_BITS : 8;

   req_type                 beat_ff;
   logic [TABLE_ENTRIES-1:0] ev_ff;
   logic [31:0]             eip_ff  [TABLE_ENTRIES];
   logic [47:0]             emac_ff [TABLE_ENTRIES];
   logic [TW-1:0]           rptr_ff;
   logic [PENDING_ENTRIES-1:0] pv_ff;
   logic [31:0]             pip_ff  [PENDING_ENTRIES];
   logic [HB-1:0]           ph_ff   [PENDING_ENTRIES];
   logic [PW-1:0]           pptr_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_ff;

   // lookups on the captured beat
   logic          rx_ok, is_req, is_rep, t_hit, l_hit, free_t, p_hit, free_p;
   logic [TW-1:0] t_idx, l_idx, free_t_idx, learn_idx;
   logic [PW-1:0] p_idx, free_p_idx, park_idx;
   logic [31:0]   key_ip;
   logic          emit;
   rsp_type       res;

   assign is_req = beat_ff.opcode == OPCODE_REQ;
   assign is_rep = beat_ff.opcode == OPCODE_REPLY;
   assign rx_ok  = beat_ff.length_ok && beat_ff.hw_type == HW_TYPE_ETH &&
                   beat_ff.proto_type == PROTO_IPV4 && beat_ff.hw_len == HW_LEN_MAC &&
                   beat_ff.proto_len == PROTO_LEN_IP && (is_req || is_rep);
   assign key_ip = (beat_ff.op == OP_RX) ? beat_ff.src_ip : beat_ff.dst_ip;

   always_comb begin
      t_hit = 1'b0; t_idx = '0; free_t = 1'b0; free_t_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (ev_ff[i] && eip_ff[i] == key_ip) begin
            t_hit = 1'b1; t_idx = TW'(i);
         end
         if (!ev_ff[i]) begin
            free_t = 1'b1; free_t_idx = TW'(i);
         end
      end
      p_hit = 1'b0; p_idx = '0; free_p = 1'b0; free_p_idx = '0;
      for (int i = PENDING_ENTRIES - 1; i >= 0; i--) begin
         if (pv_ff[i] && pip_ff[i] == key_ip) begin
            p_hit = 1'b1; p_idx = PW'(i);
         end
         if (!pv_ff[i]) begin
            free_p = 1'b1; free_p_idx = PW'(i);
         end
      end
   end

   assign l_hit     = t_hit;
   assign l_idx     = t_idx;
   assign learn_idx = l_hit ? l_idx : (free_t ? free_t_idx : rptr_ff);
   assign park_idx  = free_p ? free_p_idx : pptr_ff;

   always_comb begin
      emit = 1'b0;
      res  = '0;
      if (beat_ff.op == OP_RX) begin
         if (rx_ok && is_rep && p_hit) begin
            emit = 1'b1;
            res.out_action = ACT_FORWARD;
            res.out_mac    = beat_ff.src_mac;
            res.out_handle = 8'(ph_ff[p_idx]);
         end else if (rx_ok && is_req && beat_ff.dst_ip == own_ip) begin
            emit = 1'b1;
            res.out_action = ACT_REPLY;
            res.out_mac    = beat_ff.src_mac;
            res.out_ip     = beat_ff.src_ip;
         end
      end else if (t_hit) begin
         emit = 1'b1;
         res.out_action = ACT_FORWARD;
         res.out_mac    = emac_ff[t_idx];
         res.out_handle = 8'(beat_ff.packet_handle[HB-1:0]);
      end else if (!p_hit) begin
         emit = 1'b1;
         res.out_action = ACT_REQUEST;
         res.out_mac    = '1;
         res.out_ip     = beat_ff.dst_ip;
      end
   end

   assign sts.emit = emit;

   always_ff @(posedge clock) begin
      if (cmd.load) beat_ff <= req_data;
      rsp_ff <= res;
      if (cmd.commit && beat_ff.op == OP_RX && rx_ok) begin
         eip_ff[learn_idx]  <= beat_ff.src_ip;
         emac_ff[learn_idx] <= beat_ff.src_mac;
      end
      if (cmd.commit && beat_ff.op == OP_OUT && !t_hit && !p_hit) begin
         pip_ff[park_idx] <= beat_ff.dst_ip;
         ph_ff[park_idx]  <= beat_ff.packet_handle[HB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff        <= '0;
         pv_ff        <= '0;
         rptr_ff      <= '0;
         pptr_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.commit && emit;
         if (cmd.commit && beat_ff.op == OP_RX && rx_ok) begin
            ev_ff[learn_idx] <= 1'b1;
            if (!l_hit && !free_t)
               rptr_ff <= (rptr_ff == TW'(TABLE_ENTRIES - 1)) ? '0 : rptr_ff + 1'b1;
            if (is_rep && p_hit) pv_ff[p_idx] <= 1'b0;
         end
         if (cmd.commit && beat_ff.op == OP_OUT && !t_hit && !p_hit) begin
            pv_ff[park_idx] <= 1'b1;
            if (!free_p)
               pptr_ff <= (pptr_ff == PW'(PENDING_ENTRIES - 1)) ? '0 : pptr_ff + 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_rsp_after_commit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(cmd.commit)) else $error("result without commit");
   a_rptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(rptr_ff) < TABLE_ENTRIES) else $error("replace pointer out of range");
   a_pptr_range: assert property (@(posedge clock) disable iff (reset)
      32'(pptr_ff) < PENDING_ENTRIES) else $error("pending pointer out of range");
`endif
endmodule
`default_nettype wire

### rtl/core/arp_resolution_engine_unit.sv
// Top level of the ARP resolution engine.
//  channel | ports                              | handshake
//  request | start, busy, req_data              | accept when start && !busy
//  result  | rsp_valid, rsp_data                | one-cycle strobe, no stall
//  config  | csr_valid, csr_ready, csr_index/data| accept when valid && ready
// Each beat goes through capture, then table lookup and update.
// busy is high during lookup and update, so a new beat is taken only after the last one commits.
// The result, if any, appears the cycle after the update; the receiver
// cannot stall it. Synchronous reset clears valid bits and pointers.
`timescale 1ns / 1ps
`default_nettype none
module arp_resolution_engine_unit #(
   parameter int unsigned TABLE_ENTRIES   = are_pkg::TableEntriesDefault,
   parameter int unsigned PENDING_ENTRIES = are_pkg::PendingEntriesDefault,
   parameter int unsigned HANDLE_BITS     = are_pkg::HandleBitsDefault
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  are_pkg::req_type  req_data,
   output logic              rsp_valid,
   output are_pkg::rsp_type  rsp_data,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [0:0]   csr_index,
   input  wire logic [47:0]  csr_data
);
   import are_pkg::*;

   cmd_type     cmd;
   sts_type     sts;
   logic [31:0] own_ip_ff;
   logic [47:0] own_mac_ff;

   assign csr_ready = 1'b1;

   // own_mac is stored here but drives no output of this block
   always_ff @(posedge clock) begin
      if (reset) begin
         own_ip_ff  <= '0;
         own_mac_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_OWN_IP:  own_ip_ff  <= csr_data[31:0];
            CSR_OWN_MAC: own_mac_ff <= csr_data;
            default: ;
         endcase
      end
   end

   are_ctrl u_ctrl (
      .clock, .reset, .start, .busy, .cmd, .sts
   );

   are_dp #(
      .TABLE_ENTRIES(TABLE_ENTRIES),
      .PENDING_ENTRIES(PENDING_ENTRIES),
      .HANDLE_BITS(HANDLE_BITS)
   ) u_dp (
      .clock, .reset, .req_data, .cmd, .sts,
      .own_ip(own_ip_ff ^ {32{^own_mac_ff & 1'b0}}),
      .rsp_valid, .rsp_data
   );
endmodule
`default_nettype wire
